### sv/mcwc_pkg.sv
// ----------------------------------------------------------------------------
// mcwc_pkg
// Shared types and constants of the minutiae centroid window counter: field
// widths, configuration register codes, the configuration bundle and the
// state codes of the back end.
// ----------------------------------------------------------------------------
package mcwc_pkg;

	// Fixed widths of the port fields
	localparam int IN_COORD_W = 14;
	localparam int CNT_OUT_W  = 9;
	localparam int IMG_W      = 14;
	localparam int WIN_W      = 13;
	localparam int CFG_DATA_W = 14;
	localparam int CFG_IDX_W  = 2;

	// Width of the window bound arithmetic (coordinate plus half window)
	localparam int BND_W = 16;

	// Configuration register reset values
	localparam logic [IMG_W-1:0] IMAGE_SIZE_RST  = 14'd500;
	localparam logic [WIN_W-1:0] WINDOW_SIZE_RST = 13'd200;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH   = 2'd0,
		CFG_IMAGE_HEIGHT  = 2'd1,
		CFG_WINDOW_WIDTH  = 2'd2,
		CFG_WINDOW_HEIGHT = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [IMG_W-1:0] image_width;
		logic [IMG_W-1:0] image_height;
		logic [WIN_W-1:0] window_width;
		logic [WIN_W-1:0] window_height;
	} cfg_t;

	typedef enum logic [2:0] {
		BK_IDLE   = 3'd0,
		BK_DIV    = 3'd1,
		BK_BOUND  = 3'd2,
		BK_WALK   = 3'd3,
		BK_FINISH = 3'd4
	} back_state_t;

endpackage

### sv/mcwc_store.sv
// ----------------------------------------------------------------------------
// mcwc_store
// Point memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mcwc_store #(
	parameter int AW = 9,
	parameter int DW = 28
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem_q [2**AW];
	logic [DW-1:0] rd_data_q;

	// Write one point
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read one point, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### sv/mcwc_front.sv
// ----------------------------------------------------------------------------
// mcwc_front
// Load side: accepts items, writes points into the current bank of the
// store, keeps the running sums, count and overflow mark, and hands a job
// to the back end on the last item of a set. Two banks let one set load
// while the previous one is walked.
// ----------------------------------------------------------------------------
module mcwc_front
	import mcwc_pkg::*;
#(
	parameter int MAX_POINTS = 256,
	parameter int COORD_BITS = 14,
	localparam int CW    = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W,
	localparam int CNT_W = $clog2(MAX_POINTS + 1),
	localparam int IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	localparam int SW    = CW + CNT_W,
	localparam int JOB_W = 2 + CNT_W + 2 * SW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [IN_COORD_W-1:0] point_x,
	input  logic [IN_COORD_W-1:0] point_y,
	input  logic                  point_present,
	input  logic                  last_point,
	output logic                  wr_en,
	output logic [IW:0]           wr_addr,
	output logic [2*CW-1:0]       wr_data,
	output logic                  job_push,
	output logic [JOB_W-1:0]      job_data,
	input  logic                  bank_release
);

	typedef struct packed {
		logic             bank;
		logic             ovf;
		logic [CNT_W-1:0] cnt;
		logic [SW-1:0]    sum_x;
		logic [SW-1:0]    sum_y;
	} job_t;

	logic [SW-1:0]    sum_x_q, sum_y_q, sum_x_d, sum_y_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             ovf_q, ovf_d;
	logic             bank_q;
	logic [1:0]       pending_q;
	logic             accept, room, take;
	logic [CW-1:0]    px, py;
	job_t             job;

	// Both banks owned by the back end: hold the input
	assign full   = (pending_q == 2'd2);
	assign accept = push & ~full;

	assign px   = point_x[CW-1:0];
	assign py   = point_y[CW-1:0];
	assign room = (cnt_q < CNT_W'(MAX_POINTS));
	assign take = accept & point_present & room;

	// Store the point at the next free entry of the current bank
	assign wr_en   = take;
	assign wr_addr = {bank_q, cnt_q[IW-1:0]};
	assign wr_data = {px, py};

	// Running totals including this item
	always_comb begin
		sum_x_d = sum_x_q;
		sum_y_d = sum_y_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q | (accept & point_present & ~room);
		if (take) begin
			sum_x_d = sum_x_q + SW'(px);
			sum_y_d = sum_y_q + SW'(py);
			cnt_d   = cnt_q + 1'b1;
		end
	end

	// Hand the finished set to the back end
	assign job_push  = accept & last_point;
	assign job.bank  = bank_q;
	assign job.ovf   = ovf_d;
	assign job.cnt   = cnt_d;
	assign job.sum_x = sum_x_d;
	assign job.sum_y = sum_y_d;
	assign job_data  = job;

	// Advance totals; clear and switch bank at set end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			bank_q  <= 1'b0;
		end else if (job_push) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			bank_q  <= ~bank_q;
		end else begin
			sum_x_q <= sum_x_d;
			sum_y_q <= sum_y_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
		end
	end

	// Track banks handed off and not yet released
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else if (job_push && !bank_release) begin
			pending_q <= pending_q + 2'd1;
		end else if (!job_push && bank_release) begin
			pending_q <= pending_q - 2'd1;
		end
	end

endmodule

### sv/mcwc_job_fifo.sv
// ----------------------------------------------------------------------------
// mcwc_job_fifo
// Two-entry queue of set jobs between the load side and the back end.
// ----------------------------------------------------------------------------
module mcwc_job_fifo #(
	parameter int W = 57
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] data_in,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         empty,
	output logic         full
);

	logic [W-1:0] ent_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = ent_q[rp_q];

	// Store the job
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= data_in;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

### sv/mcwc_back.sv
// ----------------------------------------------------------------------------
// mcwc_back
// Compute side: takes a set job, divides both sums by the point count one
// quotient bit per cycle, forms the clipped window, walks the stored points
// of the job's bank one per cycle and counts those inside, then places the
// result in the output register.
// ----------------------------------------------------------------------------
module mcwc_back
	import mcwc_pkg::*;
#(
	parameter int MAX_POINTS = 256,
	parameter int COORD_BITS = 14,
	localparam int CW     = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W,
	localparam int CNT_W  = $clog2(MAX_POINTS + 1),
	localparam int IW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	localparam int SW     = CW + CNT_W,
	localparam int JOB_W  = 2 + CNT_W + 2 * SW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  job_empty,
	input  logic [JOB_W-1:0]      job_head,
	output logic                  job_pop,
	output logic                  bank_release,
	output logic                  rd_en,
	output logic [IW:0]           rd_addr,
	input  logic [2*CW-1:0]       rd_data,
	input  logic                  pop,
	output logic                  empty,
	output logic [CNT_OUT_W-1:0]  count_in_window,
	output logic [IN_COORD_W-1:0] centroid_x,
	output logic [IN_COORD_W-1:0] centroid_y,
	output logic [CNT_OUT_W-1:0]  set_size,
	output logic                  overflowed
);

	localparam int STEP_W = $clog2(SW + 1);

	typedef struct packed {
		logic             bank;
		logic             ovf;
		logic [CNT_W-1:0] cnt;
		logic [SW-1:0]    sum_x;
		logic [SW-1:0]    sum_y;
	} job_t;

	// One restoring division step: returns {remainder, quotient shift}
	function automatic logic [CNT_W+SW-1:0] div_step(
		input logic [CNT_W-1:0] rem,
		input logic [SW-1:0]    quo,
		input logic [CNT_W-1:0] d
	);
		logic [CNT_W:0] trial;
		logic           bit_q;
		logic [CNT_W-1:0] rem_n;
		trial = {rem, quo[SW-1]};
		bit_q = (trial >= {1'b0, d});
		rem_n = bit_q ? CNT_W'(trial - {1'b0, d}) : CNT_W'(trial);
		return {rem_n, quo[SW-2:0], bit_q};
	endfunction

	back_state_t      state_q, state_d;
	job_t             job;
	logic             res_load;
	logic             res_valid_q;

	logic             bank_q, ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rem_x_q, rem_y_q;
	logic [SW-1:0]    quo_x_q, quo_y_q;
	logic [STEP_W-1:0] step_q;
	logic [BND_W-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q;
	logic             nohi_x_q, nohi_y_q;
	logic [CNT_W-1:0] idx_q, inside_q;
	logic             rd_pend_s1;

	logic [BND_W-1:0] cx_b, cy_b, half_x, half_y, size_x, size_y;
	logic [BND_W-1:0] lo_x, lo_y, hix_raw, hiy_raw, hi_x, hi_y;
	logic             nohi_x, nohi_y;
	logic [BND_W-1:0] pt_x, pt_y;
	logic             in_win;

	logic [CNT_W-1:0] res_inside_q, res_size_q;
	logic [CW-1:0]    res_cx_q, res_cy_q;
	logic             res_ovf_q;

	assign job = job_t'(job_head);

	// Window bounds from the centroid, clipped to the image
	always_comb begin
		cx_b    = BND_W'(quo_x_q[CW-1:0]);
		cy_b    = BND_W'(quo_y_q[CW-1:0]);
		half_x  = BND_W'(cfg.window_width >> 1);
		half_y  = BND_W'(cfg.window_height >> 1);
		size_x  = BND_W'(cfg.image_width);
		size_y  = BND_W'(cfg.image_height);
		lo_x    = (cx_b > half_x) ? cx_b - half_x : '0;
		lo_y    = (cy_b > half_y) ? cy_b - half_y : '0;
		hix_raw = cx_b + half_x;
		hiy_raw = cy_b + half_y;
		nohi_x  = (size_x == '0);
		nohi_y  = (size_y == '0);
		hi_x    = (!nohi_x && hix_raw >= size_x) ? size_x - 1'b1 : hix_raw;
		hi_y    = (!nohi_y && hiy_raw >= size_y) ? size_y - 1'b1 : hiy_raw;
	end

	// Window test of the point read in the previous cycle
	assign pt_x   = BND_W'(rd_data[2*CW-1:CW]);
	assign pt_y   = BND_W'(rd_data[CW-1:0]);
	assign in_win = (pt_x >= lo_x_q) && (nohi_x_q || pt_x <= hi_x_q) &&
	                (pt_y >= lo_y_q) && (nohi_y_q || pt_y <= hi_y_q);

	assign rd_addr = {bank_q, idx_q[IW-1:0]};

	// Next state and control
	always_comb begin
		state_d      = state_q;
		job_pop      = 1'b0;
		bank_release = 1'b0;
		res_load     = 1'b0;
		rd_en        = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!job_empty) begin
					job_pop = 1'b1;
					if (job.cnt == '0) begin
						bank_release = 1'b1;
						state_d      = BK_FINISH;
					end else begin
						state_d = BK_DIV;
					end
				end
			end
			BK_DIV: begin
				if (step_q == STEP_W'(1)) begin
					state_d = BK_BOUND;
				end
			end
			BK_BOUND: begin
				state_d = BK_WALK;
			end
			BK_WALK: begin
				rd_en = (idx_q != cnt_q);
				if (idx_q == cnt_q && !rd_pend_s1) begin
					bank_release = 1'b1;
					state_d      = BK_FINISH;
				end
			end
			BK_FINISH: begin
				if (!res_valid_q || pop) begin
					res_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// State, read pipeline flag and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			rd_pend_s1  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= rd_en;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Job datapath: load, divide, bound, walk
	always_ff @(posedge clk) begin
		if (job_pop) begin
			bank_q   <= job.bank;
			ovf_q    <= job.ovf;
			cnt_q    <= job.cnt;
			quo_x_q  <= job.sum_x;
			quo_y_q  <= job.sum_y;
			rem_x_q  <= '0;
			rem_y_q  <= '0;
			step_q   <= STEP_W'(SW);
			idx_q    <= '0;
			inside_q <= '0;
		end
		if (state_q == BK_DIV) begin
			{rem_x_q, quo_x_q} <= div_step(rem_x_q, quo_x_q, cnt_q);
			{rem_y_q, quo_y_q} <= div_step(rem_y_q, quo_y_q, cnt_q);
			step_q             <= step_q - 1'b1;
		end
		if (state_q == BK_BOUND) begin
			lo_x_q   <= lo_x;
			hi_x_q   <= hi_x;
			nohi_x_q <= nohi_x;
			lo_y_q   <= lo_y;
			hi_y_q   <= hi_y;
			nohi_y_q <= nohi_y;
		end
		if (rd_en) begin
			idx_q <= idx_q + 1'b1;
		end
		if (rd_pend_s1 && in_win) begin
			inside_q <= inside_q + 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_inside_q <= inside_q;
			res_cx_q     <= quo_x_q[CW-1:0];
			res_cy_q     <= quo_y_q[CW-1:0];
			res_size_q   <= cnt_q;
			res_ovf_q    <= ovf_q;
		end
	end

	assign empty           = ~res_valid_q;
	assign count_in_window = CNT_OUT_W'(res_inside_q);
	assign centroid_x      = IN_COORD_W'(res_cx_q);
	assign centroid_y      = IN_COORD_W'(res_cy_q);
	assign set_size        = CNT_OUT_W'(res_size_q);
	assign overflowed      = res_ovf_q;

endmodule

### sv/minutiae_centroid_window_count_top.sv
// ----------------------------------------------------------------------------
// minutiae_centroid_window_count_top
// Minutia set centroid and window point count, with configuration registers.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive an item with push while full is low. Each item with
//   point_present stores one point (up to MAX_POINTS per set; more are
//   dropped and flagged). The item with last_point closes the set.
//   Result queue: one result per set is shown while empty is low and is
//   taken with pop. Configuration: cfg_we writes cfg_data to register
//   cfg_index (image width, image height, window width, window height).
//   Throughput: points load at one per cycle while full is low. The point
//   store has two banks, so a new set loads while the previous one is
//   processed; full rises only when both banks wait for the back end.
//   After the last item the back end divides both sums bit-serially over
//   SW = min(COORD_BITS,14) + clog2(MAX_POINTS+1) quotient bits (23 by
//   default), forms the window, then reads each stored point of the set in
//   turn; an empty set skips the division and the walk.
//   Reset: sums, counts and queues clear at once, registers return to
//   500/500/200/200; no memory clearing is needed.
//   A stalled result holds in the output register; the back end then waits,
//   and the front stalls once both banks are taken.
// ----------------------------------------------------------------------------
module minutiae_centroid_window_count_top
	import mcwc_pkg::*;
#(
	parameter int MAX_POINTS = 256,
	parameter int COORD_BITS = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  push,
	output logic                  full,
	input  logic [IN_COORD_W-1:0] point_x,
	input  logic [IN_COORD_W-1:0] point_y,
	input  logic                  point_present,
	input  logic                  last_point,
	output logic                  empty,
	input  logic                  pop,
	output logic [CNT_OUT_W-1:0]  count_in_window,
	output logic [IN_COORD_W-1:0] centroid_x,
	output logic [IN_COORD_W-1:0] centroid_y,
	output logic [CNT_OUT_W-1:0]  set_size,
	output logic                  overflowed
);

	localparam int CW    = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int IW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int SW    = CW + CNT_W;
	localparam int JOB_W = 2 + CNT_W + 2 * SW;

	cfg_t             cfg_q;
	logic             wr_en, rd_en;
	logic [IW:0]      wr_addr, rd_addr;
	logic [2*CW-1:0]  wr_data, rd_data;
	logic             job_push, job_pop, job_empty, job_full, bank_release;
	logic [JOB_W-1:0] job_data, job_head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= IMAGE_SIZE_RST;
			cfg_q.image_height  <= IMAGE_SIZE_RST;
			cfg_q.window_width  <= WINDOW_SIZE_RST;
			cfg_q.window_height <= WINDOW_SIZE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data[IMG_W-1:0];
				CFG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data[IMG_W-1:0];
				CFG_WINDOW_WIDTH:  cfg_q.window_width  <= cfg_data[WIN_W-1:0];
				CFG_WINDOW_HEIGHT: cfg_q.window_height <= cfg_data[WIN_W-1:0];
			endcase
		end
	end

	mcwc_front #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.point_x       (point_x),
		.point_y       (point_y),
		.point_present (point_present),
		.last_point    (last_point),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.job_push      (job_push),
		.job_data      (job_data),
		.bank_release  (bank_release)
	);

	mcwc_store #(
		.AW (IW + 1),
		.DW (2 * CW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mcwc_job_fifo #(
		.W (JOB_W)
	) u_job_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (job_push),
		.data_in (job_data),
		.pop     (job_pop),
		.head    (job_head),
		.empty   (job_empty),
		.full    (job_full)
	);

	mcwc_back #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.job_empty       (job_empty),
		.job_head        (job_head),
		.job_pop         (job_pop),
		.bank_release    (bank_release),
		.rd_en           (rd_en),
		.rd_addr         (rd_addr),
		.rd_data         (rd_data),
		.pop             (pop),
		.empty           (empty),
		.count_in_window (count_in_window),
		.centroid_x      (centroid_x),
		.centroid_y      (centroid_y),
		.set_size        (set_size),
		.overflowed      (overflowed)
	);

	// The back end never takes a job from an empty queue
	ap_pop_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !job_empty)
		else $error("job taken from empty job queue");

	// Bank accounting keeps the job queue from overrunning
	ap_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !job_full)
		else $error("job pushed into full job queue");

	// A point count inside the window never exceeds the set size
	ap_count_le_size: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && MAX_POINTS < 512) |-> (count_in_window <= set_size))
		else $error("window count exceeds set size");

endmodule

### tb/sv/minutiae_centroid_window_count_top_tb.sv
// ----------------------------------------------------------------------------
// minutiae_centroid_window_count_top_tb
// Self-checking bench for the minutia centroid window counter. Point sets are
// queued per configuration phase and fed through the input queue with random
// gaps. A bench-side model of the centroid, the clipped window and the point
// count predicts one result per closed set. The output side pops with random
// stalls, and every popped result is checked field by field.
// ----------------------------------------------------------------------------
module minutiae_centroid_window_count_top_tb;
	import mcwc_pkg::*;

	localparam int STORE_DEPTH = 256;
	localparam int COORD_MAX   = (1 << IN_COORD_W) - 1;
	localparam int SETTLE_CYC  = 330;

	typedef struct {
		logic [IN_COORD_W-1:0] x;
		logic [IN_COORD_W-1:0] y;
		logic                  present;
		logic                  last;
	} point_item_t;

	typedef struct {
		logic [CNT_OUT_W-1:0]  hits;
		logic [IN_COORD_W-1:0] cx;
		logic [IN_COORD_W-1:0] cy;
		logic [CNT_OUT_W-1:0]  size;
		logic                  ovf;
	} set_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we    = 1'b0;
	cfg_index_t            cfg_index = CFG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  push      = 1'b0;
	logic                  full;
	logic [IN_COORD_W-1:0] point_x   = '0;
	logic [IN_COORD_W-1:0] point_y   = '0;
	logic                  point_present = 1'b0;
	logic                  last_point    = 1'b0;
	logic                  empty;
	logic                  pop       = 1'b0;
	logic [CNT_OUT_W-1:0]  count_in_window;
	logic [IN_COORD_W-1:0] centroid_x;
	logic [IN_COORD_W-1:0] centroid_y;
	logic [CNT_OUT_W-1:0]  set_size;
	logic                  overflowed;

	minutiae_centroid_window_count_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.push            (push),
		.full            (full),
		.point_x         (point_x),
		.point_y         (point_y),
		.point_present   (point_present),
		.last_point      (last_point),
		.empty           (empty),
		.pop             (pop),
		.count_in_window (count_in_window),
		.centroid_x      (centroid_x),
		.centroid_y      (centroid_y),
		.set_size        (set_size),
		.overflowed      (overflowed)
	);

	// Bench copy of the block state and registers
	int unsigned img_w, img_h, win_w, win_h;
	logic [IN_COORD_W-1:0] held_x [STORE_DEPTH];
	logic [IN_COORD_W-1:0] held_y [STORE_DEPTH];
	int unsigned sum_x, sum_y;
	int          pts_held;
	logic        pts_lost;

	point_item_t pending_items[$];
	set_result_t results_due[$];
	int          errors;
	logic        in_fire  = 1'b0;
	logic        out_fire = 1'b0;
	int          push_gap, push_calm, pop_gap, pop_calm;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic report(string what);
		$display("ERROR @%0t: %s", $realtime, what);
		errors++;
	endtask

	// Mostly short gaps, a few long ones, with calm stretches of none
	function automatic int pick_gap(inout int calm);
		int roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(99);
		if (roll < 2) begin
			calm = $urandom_range(60, 20);
			return 0;
		end
		if (roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Bounds of the window on one axis, inclusive; size zero leaves no top clip
	function automatic void axis_window(input int unsigned centre, input int unsigned span,
			input int unsigned size, output int unsigned lo, output int unsigned hi);
		int unsigned half;
		half = span / 2;
		lo = (centre > half) ? centre - half : 0;
		hi = centre + half;
		if (size == 0)
			hi = 32'hFFFF_FFFF;
		else if (hi >= size)
			hi = size - 1;
	endfunction

	function automatic set_result_t close_set();
		set_result_t r;
		int unsigned cx, cy, x0, x1, y0, y1, hits;
		cx = 0;
		cy = 0;
		hits = 0;
		if (pts_held != 0) begin
			cx = sum_x / pts_held;
			cy = sum_y / pts_held;
			axis_window(cx, win_w, img_w, x0, x1);
			axis_window(cy, win_h, img_h, y0, y1);
			for (int i = 0; i < pts_held; i++)
				if (held_x[i] >= x0 && held_x[i] <= x1 && held_y[i] >= y0 && held_y[i] <= y1)
					hits++;
		end
		r.hits = hits[CNT_OUT_W-1:0];
		r.cx   = cx[IN_COORD_W-1:0];
		r.cy   = cy[IN_COORD_W-1:0];
		r.size = pts_held[CNT_OUT_W-1:0];
		r.ovf  = pts_lost;
		return r;
	endfunction

	// Store or drop a point, and close the set on the last item
	task automatic take_item(point_item_t it);
		if (it.present) begin
			if (pts_held < STORE_DEPTH) begin
				held_x[pts_held] = it.x;
				held_y[pts_held] = it.y;
				sum_x += it.x;
				sum_y += it.y;
				pts_held++;
			end else begin
				pts_lost = 1'b1;
			end
		end
		if (it.last) begin
			results_due.insert(results_due.size(), close_set());
			sum_x = 0;
			sum_y = 0;
			pts_held = 0;
			pts_lost = 1'b0;
		end
	endtask

	task automatic check_result();
		set_result_t want;
		if (results_due.size() == 0) begin
			report($sformatf("result with no set pending: count %0d size %0d",
				count_in_window, set_size));
			return;
		end
		want = results_due.pop_front();
		if (count_in_window !== want.hits)
			report($sformatf("count_in_window %0d, expected %0d", count_in_window, want.hits));
		if (centroid_x !== want.cx)
			report($sformatf("centroid_x %0d, expected %0d", centroid_x, want.cx));
		if (centroid_y !== want.cy)
			report($sformatf("centroid_y %0d, expected %0d", centroid_y, want.cy));
		if (set_size !== want.size)
			report($sformatf("set_size %0d, expected %0d", set_size, want.size));
		if (overflowed !== want.ovf)
			report($sformatf("overflowed %0b, expected %0b", overflowed, want.ovf));
	endtask

	// Sample both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_result();
			if (push && !full)
				take_item('{point_x, point_y, point_present, last_point});
		end
		in_fire  <= arst_n && push && !full;
		out_fire <= arst_n && pop && !empty;
	end

	// Input driver: hold the item until taken, then gap or advance
	always @(negedge clk) begin
		point_item_t it;
		if (arst_n && (!push || in_fire)) begin
			if (push_gap > 0) begin
				push <= 1'b0;
				push_gap--;
			end else if (pending_items.size() != 0) begin
				it = pending_items.pop_front();
				point_x       <= it.x;
				point_y       <= it.y;
				point_present <= it.present;
				last_point    <= it.last;
				push          <= 1'b1;
				push_gap = pick_gap(push_calm);
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Output driver: stall pop for a random time after each taken result
	always @(negedge clk) begin
		if (out_fire)
			pop_gap = pick_gap(pop_calm);
		if (pop_gap > 0) begin
			pop <= 1'b0;
			pop_gap--;
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic add_item(int unsigned x, int unsigned y, bit present, bit last);
		point_item_t it;
		it.x = x[IN_COORD_W-1:0];
		it.y = y[IN_COORD_W-1:0];
		it.present = present;
		it.last = last;
		pending_items.insert(pending_items.size(), it);
	endtask

	function automatic int unsigned near(int unsigned centre, int spread);
		int v;
		v = int'(centre) + $urandom_range(2 * spread) - spread;
		if (v < 0)
			v = 0;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v;
	endfunction

	// Queue one set: clustered or spread points, stray items, and the last mark on the final point or a trailing item
	task automatic add_set(int n);
		bit          wide, tail_mark;
		int unsigned cx, cy, rx, ry;
		int          spread;
		wide = ($urandom_range(4) == 0);
		tail_mark = $urandom_range(1);
		if (n == 0)
			tail_mark = 1'b1;
		rx = (img_w == 0) ? COORD_MAX : img_w + 40;
		ry = (img_h == 0) ? COORD_MAX : img_h + 40;
		cx = $urandom_range(rx > COORD_MAX ? COORD_MAX : rx);
		cy = $urandom_range(ry > COORD_MAX ? COORD_MAX : ry);
		spread = (win_w + win_h) / 4 + $urandom_range(60, 1);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0)
				add_item($urandom, $urandom, 1'b0, 1'b0);
			if (wide)
				add_item($urandom, $urandom, 1'b1, !tail_mark && i == n - 1);
			else
				add_item(near(cx, spread), near(cy, spread), 1'b1, !tail_mark && i == n - 1);
		end
		if (tail_mark)
			add_item($urandom, $urandom, 1'b0, 1'b1);
	endtask

	task automatic add_random_sets(int budget);
		int target, roll;
		target = pending_items.size() + budget;
		while (pending_items.size() < target) begin
			roll = $urandom_range(19);
			if (roll == 0)
				add_set(0);
			else if (roll < 3)
				add_set($urandom_range(60, 20));
			else
				add_set($urandom_range(12, 1));
		end
	endtask

	// Write all four registers while the block is idle
	task automatic set_config(int unsigned iw, int unsigned ih, int unsigned ww,
			int unsigned wh);
		cfg_index_t  idx [4];
		int unsigned val [4];
		idx = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_WINDOW_WIDTH, CFG_WINDOW_HEIGHT};
		val = '{iw, ih, ww, wh};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i][CFG_DATA_W-1:0];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		img_w = iw & ((1 << IMG_W) - 1);
		img_h = ih & ((1 << IMG_W) - 1);
		win_w = ww & ((1 << WIN_W) - 1);
		win_h = wh & ((1 << WIN_W) - 1);
	endtask

	// Hold the sender until every set has come back, then let the block settle
	task automatic drain();
		while (pending_items.size() != 0 || push || results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	function automatic int unsigned rand_image();
		if ($urandom_range(3) == 0)
			return $urandom_range(COORD_MAX);
		return $urandom_range(1000, 100);
	endfunction

	function automatic int unsigned rand_window();
		if ($urandom_range(4) == 0)
			return $urandom_range(COORD_MAX);
		return $urandom_range(600);
	endfunction

	initial begin
		arst_n = 1'b0;
		img_w = IMAGE_SIZE_RST;
		img_h = IMAGE_SIZE_RST;
		win_w = WINDOW_SIZE_RST;
		win_h = WINDOW_SIZE_RST;
		sum_x = 0;
		sum_y = 0;
		pts_held = 0;
		pts_lost = 1'b0;
		errors = 0;
		push_gap = 0;
		push_calm = 0;
		pop_gap = 0;
		pop_calm = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset registers: empty set, extremes, point riding on the last mark
		add_item(16383, 16383, 1'b0, 1'b1);
		add_item(0, 0, 1'b1, 1'b1);
		add_item(16383, 16383, 1'b1, 1'b0);
		add_item(16383, 16383, 1'b1, 1'b0);
		add_item(0, 0, 1'b0, 1'b1);
		add_item(5461, 10922, 1'b0, 1'b0);
		add_item(0, 16383, 1'b1, 1'b0);
		add_item(16383, 0, 1'b1, 1'b1);
		add_item(0, 0, 1'b1, 1'b0);
		add_item(200, 200, 1'b1, 1'b0);
		add_item(100, 100, 1'b1, 1'b1);
		add_item(499, 499, 1'b1, 1'b0);
		add_item(401, 401, 1'b1, 1'b0);
		add_item(450, 450, 1'b1, 1'b1);
		add_item(349, 551, 1'b1, 1'b0);
		add_item(551, 349, 1'b1, 1'b0);
		add_item(450, 450, 1'b1, 1'b1);
		drain();

		// Register extremes
		set_config(COORD_MAX, COORD_MAX, (1 << WIN_W) - 1, (1 << WIN_W) - 1);
		add_item(0, 0, 1'b1, 1'b0);
		add_item(16383, 16383, 1'b1, 1'b1);
		add_random_sets(60);
		drain();
		set_config(0, 0, 0, 0);
		add_item(16383, 16383, 1'b1, 1'b1);
		add_random_sets(60);
		drain();
		set_config(1, 1, 1, 1);
		add_item(0, 0, 1'b1, 1'b0);
		add_item(1, 1, 1'b1, 1'b1);
		add_random_sets(60);
		drain();

		// Full store, then a set that runs past capacity
		set_config(500, 500, 200, 200);
		for (int i = 0; i < STORE_DEPTH; i++)
			add_item(near(250, 240), near(250, 240), 1'b1, i == STORE_DEPTH - 1);
		add_set(STORE_DEPTH + $urandom_range(8, 1));
		add_random_sets(30);
		drain();

		// Random register settings
		for (int p = 0; p < 7; p++) begin
			set_config(rand_image(), rand_image(), rand_window(), rand_window());
			add_random_sets(60);
			drain();
		end

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### filelist.f
sv/mcwc_pkg.sv
sv/mcwc_store.sv
sv/mcwc_front.sv
sv/mcwc_job_fifo.sv
sv/mcwc_back.sv
sv/minutiae_centroid_window_count_top.sv
tb/sv/minutiae_centroid_window_count_top_tb.sv
